// ----- hdl/urdiv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urdiv_pkg
// Shared constants for the pipelined unsigned restoring divider.
// ----------------------------------------------------------------------------
package urdiv_pkg;

   // Default operand and quotient width
   localparam int unsigned DATA_WIDTH_DEF = 64;

endpackage : urdiv_pkg
`default_nettype wire

// ----- hdl/urdiv_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urdiv_stage
// One registered step of restoring division: shift the next dividend bit
// into the partial remainder, trial-subtract the divisor, keep the
// difference when it does not go negative, and shift the quotient bit in.
// ----------------------------------------------------------------------------
module urdiv_stage #(
   parameter int unsigned DATA_WIDTH = urdiv_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [DATA_WIDTH-1:0] in_rem,
   input  wire logic [DATA_WIDTH-1:0] in_nq,
   input  wire logic [DATA_WIDTH-1:0] in_div,
   output logic                       out_valid,
   output logic [DATA_WIDTH-1:0]      out_rem,
   output logic [DATA_WIDTH-1:0]      out_nq,
   output logic [DATA_WIDTH-1:0]      out_div
);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] nq_ff;
   logic [DATA_WIDTH-1:0] nq_in;
   logic [DATA_WIDTH-1:0] div_ff;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  take;

   // Trial subtract on the remainder widened by the bit shifted out of the top
   always_comb begin
      shifted = {in_rem, in_nq[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, in_div};
      take    = (shifted >= {1'b0, in_div});
      rem_in  = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      nq_in   = {in_nq[DATA_WIDTH-2:0], take};
   end

   // Advance the valid bit; clear it on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Advance the data word
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      div_ff <= in_div;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_nq    = nq_ff;
   assign out_div   = div_ff;

   // The partial remainder always stays below a non-zero divisor
   a_rem_below_div : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (div_ff != '0)) |-> (rem_ff < div_ff))
      else $error("urdiv_stage: partial remainder not below divisor");

   // A valid word here came from a valid word at this stage's input
   a_valid_origin : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> $past(in_valid))
      else $error("urdiv_stage: valid bit without a source word");

   // The divisor travels with its word unchanged
   a_div_carried : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (div_ff == $past(in_div)))
      else $error("urdiv_stage: divisor changed between steps");

endmodule : urdiv_stage
`default_nettype wire

// ----- hdl/unsigned_restoring_divider_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_restoring_divider_core
// Fully pipelined unsigned restoring divider giving floor(dividend/divisor).
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_dividend and req_divisor and raise start for one cycle; the
//   word is taken at that clock edge when busy is low. busy is always low:
//   a new division may enter in every cycle.
//   The quotient appears on rsp_quotient with rsp_valid high for exactly
//   one cycle, once the word has passed through every stage, and is taken
//   by the receiver in that cycle.
//   Throughput is one quotient per cycle. The word passes through a chain
//   of DATA_WIDTH stages, each holding one compare-and-subtract of the
//   divisor against the partial remainder.
//   A zero divisor is not trapped: the quotient comes out as all ones.
//   The remainder is not returned.
//   Reset clears every stage's valid bit, so nothing is delivered for words
//   in flight at reset. The receiver cannot stall; results are delivered
//   in the order the words were taken.
// ----------------------------------------------------------------------------
module unsigned_restoring_divider_core #(
   parameter int unsigned DATA_WIDTH = urdiv_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [DATA_WIDTH-1:0] req_dividend,
   input  wire logic [DATA_WIDTH-1:0] req_divisor,
   output logic                       rsp_valid,
   output logic [DATA_WIDTH-1:0]      rsp_quotient
);

   logic                  valid_w [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem_w   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] nq_w    [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] div_w   [0:DATA_WIDTH];

   // Pipeline never holds off the sender
   assign busy = 1'b0;

   // Feed the first step: empty remainder, dividend in the shift word
   assign valid_w[0] = start && !busy;
   assign rem_w[0]   = '0;
   assign nq_w[0]    = req_dividend;
   assign div_w[0]   = req_divisor;

   // One stage per quotient bit, most significant first
   for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
      urdiv_stage #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[g]),
         .in_rem    (rem_w[g]),
         .in_nq     (nq_w[g]),
         .in_div    (div_w[g]),
         .out_valid (valid_w[g+1]),
         .out_rem   (rem_w[g+1]),
         .out_nq    (nq_w[g+1]),
         .out_div   (div_w[g+1])
      );
   end

   // After the last step the shift word holds the whole quotient
   assign rsp_valid    = valid_w[DATA_WIDTH];
   assign rsp_quotient = nq_w[DATA_WIDTH];

   // Every result matches a word taken earlier at the pipeline input
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, DATA_WIDTH))
      else $error("divider: result without a matching request");

   // Zero divisor yields all ones
   a_div_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_divisor == '0, DATA_WIDTH)) |-> (rsp_quotient == '1))
      else $error("divider: zero divisor did not give all ones");

   // Unit divisor passes the dividend through
   a_div_one : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_divisor == DATA_WIDTH'(1), DATA_WIDTH))
         |-> (rsp_quotient == $past(req_dividend, DATA_WIDTH)))
      else $error("divider: unit divisor did not return the dividend");

endmodule : unsigned_restoring_divider_core
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined unsigned restoring divider. A queue
// of division words, directed corner cases first and then random operands,
// feeds a driver that issues one word per start handshake with random gaps.
// Every accepted word is predicted by a bit-serial restoring division and
// the monitor compares each strobed quotient with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned WIDTH = urdiv_pkg::DATA_WIDTH_DEF;
   localparam logic [WIDTH-1:0] ALL_ONES = '1;
   localparam logic [WIDTH-1:0] TOP_BIT = {1'b1, {(WIDTH-1){1'b0}}};
   localparam int unsigned RANDOM_WORDS = 550;

   // One division as queued for the driver
   typedef struct {
      logic [WIDTH-1:0] dividend;
      logic [WIDTH-1:0] divisor;
      int unsigned      gap_pct;
      bit               drain_first;
   } division_type;

   // One quotient awaited from the pipeline, with its operands for the log
   typedef struct {
      logic [WIDTH-1:0] dividend;
      logic [WIDTH-1:0] divisor;
      logic [WIDTH-1:0] quotient;
   } quotient_due_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [WIDTH-1:0] req_dividend = '0;
   logic [WIDTH-1:0] req_divisor = '0;
   logic             rsp_valid;
   logic [WIDTH-1:0] rsp_quotient;

   division_type     divisions_pending[$];
   quotient_due_type quotients_due[$];
   quotient_due_type oldest_due;
   division_type     next_word;
   bit               issue_now;
   bit               word_taken = 1'b0;
   int unsigned      words_total = 0;
   int unsigned      words_taken = 0;
   int unsigned      mismatch_count = 0;

   unsigned_restoring_divider_core #(
      .DATA_WIDTH (WIDTH)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .rsp_valid    (rsp_valid),
      .rsp_quotient (rsp_quotient)
   );

   always #5 clock = ~clock;

   // Long division from the top bit down, with a remainder one bit wider
   // than the data so that divisors above half range still divide exactly
   function automatic logic [WIDTH-1:0] restoring_quotient(input logic [WIDTH-1:0] num,
                                                           input logic [WIDTH-1:0] den);
      logic [WIDTH:0]   part;
      logic [WIDTH-1:0] quo;
      int               b;
      part = '0;
      quo = '0;
      for (b = WIDTH - 1; b >= 0; b--) begin
         part = {part[WIDTH-1:0], num[b]};
         if (part >= {1'b0, den}) begin
            part = part - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   task automatic report_mismatch(input string detail);
      $display("[%0t] mismatch: %s", $realtime, detail);
      mismatch_count++;
   endtask

   task automatic add_division(input logic [WIDTH-1:0] dividend,
                               input logic [WIDTH-1:0] divisor,
                               input int unsigned gap_pct,
                               input bit drain_first);
      division_type d;
      d.dividend = dividend;
      d.divisor = divisor;
      d.gap_pct = gap_pct;
      d.drain_first = drain_first;
      divisions_pending.push_back(d);
      words_total++;
   endtask

   // Operand with a bias towards zero, all ones, powers of two and short values
   function automatic logic [WIDTH-1:0] random_operand();
      logic [WIDTH-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         0: v = '0;
         1: v = ALL_ONES;
         2: v = TOP_BIT >> $urandom_range(WIDTH - 1);
         3, 4, 5: ;
         default: v = v >> $urandom_range(WIDTH - 1);
      endcase
      return v;
   endfunction

   // Driver: hold the word until taken, then issue the next or leave a gap
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || word_taken) begin
         issue_now = 1'b0;
         if (divisions_pending.size() != 0) begin
            next_word = divisions_pending[0];
            if (!(next_word.drain_first && quotients_due.size() != 0))
               issue_now = ($urandom_range(99) >= next_word.gap_pct);
         end
         if (issue_now) begin
            void'(divisions_pending.pop_front());
            start <= 1'b1;
            req_dividend <= next_word.dividend;
            req_divisor <= next_word.divisor;
         end else begin
            // Scramble the idle operands: they must be ignored
            start <= 1'b0;
            req_dividend <= {$urandom, $urandom};
            req_divisor <= {$urandom, $urandom};
         end
      end
   end

   // Monitor: check strobed quotients, predict each word taken
   always @(posedge clock) begin
      if (reset) begin
         word_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (quotients_due.size() == 0) begin
               report_mismatch($sformatf("unexpected quotient %h", rsp_quotient));
            end else begin
               oldest_due = quotients_due.pop_front();
               if (rsp_quotient !== oldest_due.quotient)
                  report_mismatch($sformatf("%h / %h: quotient %h, predicted %h",
                                            oldest_due.dividend, oldest_due.divisor,
                                            rsp_quotient, oldest_due.quotient));
            end
         end
         word_taken <= start && !busy;
         if (start && !busy) begin
            quotients_due.push_back('{dividend: req_dividend, divisor: req_divisor,
                                      quotient: restoring_quotient(req_dividend, req_divisor)});
            words_taken++;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      logic [WIDTH-1:0] a;
      logic [WIDTH-1:0] b;
      int unsigned      i;
      int unsigned      gap;

      // Directed corners: zero divisor, unit divisor, extremes, divisors
      // above half range, dividend below and equal to divisor
      add_division('0, '0, 34, 1'b0);
      add_division(ALL_ONES, '0, 34, 1'b0);
      add_division(WIDTH'(12345), '0, 34, 1'b0);
      add_division('0, WIDTH'(1), 34, 1'b0);
      add_division(ALL_ONES, WIDTH'(1), 34, 1'b0);
      add_division(ALL_ONES, ALL_ONES, 34, 1'b0);
      add_division(ALL_ONES - 1, ALL_ONES, 34, 1'b0);
      add_division('0, ALL_ONES, 34, 1'b0);
      add_division(TOP_BIT, TOP_BIT, 34, 1'b0);
      add_division(ALL_ONES, TOP_BIT, 34, 1'b0);
      add_division(TOP_BIT - 1, TOP_BIT, 34, 1'b0);
      add_division(ALL_ONES, TOP_BIT + 1, 34, 1'b0);
      add_division(ALL_ONES, WIDTH'(2), 34, 1'b0);
      add_division(ALL_ONES, WIDTH'(3), 34, 1'b0);
      add_division(TOP_BIT, WIDTH'(3), 34, 1'b0);
      add_division(WIDTH'(100), WIDTH'(7), 34, 1'b0);
      add_division(WIDTH'(7), WIDTH'(100), 34, 1'b0);
      add_division(WIDTH'(1), WIDTH'(1), 0, 1'b1);
      add_division({(WIDTH/4){4'hA}}, {(WIDTH/4){4'h5}}, 0, 1'b0);
      add_division({(WIDTH/4){4'h5}}, {(WIDTH/4){4'hA}}, 0, 1'b0);

      // Random words in three stretches: light gaps, heavy gaps, none;
      // each stretch opens with the pipeline drained
      for (i = 0; i < RANDOM_WORDS; i++) begin
         gap = (i < RANDOM_WORDS / 3) ? 34 : (i < 2 * RANDOM_WORDS / 3) ? 82 : 0;
         a = random_operand();
         case ($urandom_range(7))
            0: b = a >> $urandom_range(WIDTH - 1);
            1: b = a + WIDTH'($urandom_range(3)) - 1;
            default: b = random_operand();
         endcase
         add_division(a, b, gap, i == 0 || i == RANDOM_WORDS / 3 || i == 2 * RANDOM_WORDS / 3);
      end

      // Release reset on a falling clock edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every word is taken and every quotient has come back
      while (words_taken < words_total || quotients_due.size() != 0)
         @(negedge clock);
      repeat (WIDTH + 16) @(posedge clock);

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
